[rtl/core/tcfs_pkg.sv]
// ----------------------------------------------------------------------------
// tcfs_pkg
// Shared types and constants of the tilt complementary filter servo block:
// sequencer states, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tcfs_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_A,
		ST_SQ_B,
		ST_SQ_C,
		ST_SQRT,
		ST_COR_INIT,
		ST_COR_RUN,
		ST_COR_DONE,
		ST_F_RATE,
		ST_F_GAIN,
		ST_F_PRED,
		ST_F_LO,
		ST_F_HI,
		ST_F_SUM,
		ST_SV_INIT,
		ST_SV_DIV,
		ST_SV_DONE,
		ST_DONE
	} state_t;

	localparam logic [2:0] REG_ALPHA     = 3'd0;
	localparam logic [2:0] REG_GAIN      = 3'd1;
	localparam logic [2:0] REG_RANGE     = 3'd2;
	localparam logic [2:0] REG_SERVO_MIN = 3'd3;
	localparam logic [2:0] REG_SERVO_MAX = 3'd4;

	localparam int TABLE_LEN = 24;
	localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;
	// 180 degrees in the CORDIC angle scale of 2^16 per degree.
	localparam logic signed [31:0] HALF_TURN = 32'sd11796480;

	// atan(2^-i) in degrees times 2^16, rounded.
	function automatic logic [21:0] atan_entry(input logic [4:0] idx);
		logic [21:0] v;
		case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/tilt_complementary_filter_servo.sv]
// ----------------------------------------------------------------------------
// tilt_complementary_filter_servo
// Complementary tilt filter on two axes from one IMU sample per item, with
// CORDIC accelerometer angles, gyro integration and servo position mapping.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | accel_x/y/z, gyro_x/y, ms
//  out     | output    | out_valid / out_stall| tilt_x/y, servo_x/y
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item passes from accept to the result register through the
// 16-step square root, the two CORDIC passes and the two 17-step servo
// divisions on the shared units. in_stall is high from accept until the
// result is loaded; a waiting result in the output register does not
// block the next item.
// Reset clears both angles and loads the register defaults; cfg_ready is
// always high.
module tilt_complementary_filter_servo #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic        [15:0] elapsed_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] tilt_x,
	output logic signed [15:0] tilt_y,
	output logic        [7:0]  servo_x,
	output logic        [7:0]  servo_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [23:0] cfg_data
);
	import tcfs_pkg::*;

	localparam int CW = ($clog2(CORDIC_STEPS) > 5) ? $clog2(CORDIC_STEPS) : 5;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic axis_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic [15:0] ms_q;

	logic [15:0] alpha_q;
	logic [23:0] gain_q;
	logic [7:0]  range_q, smin_q, smax_q;

	logic signed [33:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [59:0] mul_p, prod_q;

	logic [31:0] n_q;
	logic [18:0] rem_q;
	logic [15:0] root_q;

	logic signed [39:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic zero_q;
	logic signed [15:0] acc_x_q, acc_y_q, angle_x_q, angle_y_q;

	logic signed [41:0] d_q;
	logic [37:0] lo_q;

	logic [16:0] num_q;
	logic neg_q;
	logic [9:0] den_q;
	logic [10:0] srem_q;
	logic [7:0] servo_x_q, servo_y_q;

	logic out_valid_q;
	logic signed [15:0] tilt_x_q, tilt_y_q;
	logic [7:0] sout_x_q, sout_y_q;

	// Selections shared by the datapath steps.
	logic signed [15:0] rate_sel, ang_sel, acc_sel;
	assign rate_sel = axis_q ? gy_q : gx_q;
	assign ang_sel  = axis_q ? angle_y_q : angle_x_q;
	assign acc_sel  = axis_q ? acc_y_q : acc_x_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign tilt_x    = tilt_x_q;
	assign tilt_y    = tilt_y_q;
	assign servo_x   = sout_x_q;
	assign servo_y   = sout_y_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Shared multiplier operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ_A: begin
				mul_a = 34'(ay_q);
				mul_b = 26'(ay_q);
			end
			ST_SQ_B: begin
				mul_a = 34'(az_q);
				mul_b = 26'(az_q);
			end
			ST_F_RATE: begin
				mul_a = 34'(rate_sel);
				mul_b = $signed({10'd0, ms_q});
			end
			ST_F_GAIN: begin
				mul_a = prod_q[33:0];
				mul_b = $signed({2'd0, gain_q});
			end
			ST_F_LO: begin
				mul_a = $signed({13'd0, d_q[20:0]});
				mul_b = $signed({10'd0, alpha_q});
			end
			ST_F_HI: begin
				mul_a = 34'($signed(d_q[41:21]));
				mul_b = $signed({10'd0, alpha_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Square root step.
	logic [18:0] rem_sh, trial;
	assign rem_sh = {rem_q[16:0], n_q[31:30]};
	assign trial  = {1'b0, root_q, 2'b01};

	// CORDIC start values and step.
	logic signed [17:0] cy_src, cx_src, cx_abs, cy_abs;
	logic cx_neg;
	assign cy_src = axis_q ? -18'(ax_q) : 18'(ay_q);
	assign cx_src = axis_q ? $signed({2'b00, root_q}) : 18'(az_q);
	assign cx_neg = cx_src < 0;
	assign cx_abs = cx_neg ? -cx_src : cx_src;
	assign cy_abs = cx_neg ? -cy_src : cy_src;

	logic signed [39:0] sh_x, sh_y;
	logic signed [31:0] t_ang;
	assign sh_x  = cx_q >>> cnt_q;
	assign sh_y  = cy_q >>> cnt_q;
	assign t_ang = $signed({10'd0, atan_entry(cnt_q[4:0])});

	logic signed [31:0] z_rnd;
	logic signed [15:0] z_ang;
	assign z_rnd = (cz_q + 32'sd256) >>> 9;
	always_comb begin
		if (zero_q)
			z_ang = '0;
		else if (z_rnd > 32'(ANGLE_LIMIT))
			z_ang = ANGLE_LIMIT;
		else if (z_rnd < -32'(ANGLE_LIMIT))
			z_ang = -ANGLE_LIMIT;
		else
			z_ang = z_rnd[15:0];
	end

	// Gyro prediction and blend.
	logic signed [59:0] g_full;
	logic signed [45:0] p_sum;
	logic signed [41:0] p_c;
	assign g_full = (prod_q + 60'sd32768) >>> 16;
	assign p_sum  = (46'(ang_sel) <<< 8) + g_full[45:0];
	always_comb begin
		if (p_sum > (46'sd1 <<< 40))
			p_c = 42'sd1 <<< 40;
		else if (p_sum < -(46'sd1 <<< 40))
			p_c = -(42'sd1 <<< 40);
		else
			p_c = p_sum[41:0];
	end

	logic signed [61:0] blend, blend_sh;
	logic signed [15:0] new_ang;
	// alpha*p + (1-alpha)*acc is formed as alpha*(p - acc) + acc.
	assign blend = (62'(prod_q) <<< 21) + $signed({24'd0, lo_q})
		+ (62'(acc_sel) <<< 24) + 62'sd8388608;
	assign blend_sh = blend >>> 24;
	always_comb begin
		if (blend_sh > 62'(ANGLE_LIMIT))
			new_ang = ANGLE_LIMIT;
		else if (blend_sh < -62'(ANGLE_LIMIT))
			new_ang = -ANGLE_LIMIT;
		else
			new_ang = blend_sh[15:0];
	end

	// Servo mapping numerator and divider step.
	logic signed [15:0] deg;
	logic [8:0] r_eff;
	logic signed [11:0] t_sum;
	logic signed [19:0] num;
	logic [19:0] num_abs;
	always_comb begin
		deg = ang_sel >>> 7;
		if (ang_sel < 0 && ang_sel[6:0] != 7'd0)
			deg = deg + 16'sd1;
	end
	assign r_eff   = (range_q == 8'd0) ? 9'd1 : {1'b0, range_q};
	assign t_sum   = 12'(deg) + $signed({3'd0, r_eff});
	assign num     = (20'(t_sum) <<< 7) + (20'(t_sum) <<< 5)
		+ (20'(t_sum) <<< 4) + (20'(t_sum) <<< 2);
	assign num_abs = (num < 0) ? 20'(-num) : 20'(num);

	logic [10:0] div_sh;
	logic div_ge;
	assign div_sh = {srem_q[9:0], num_q[16]};
	assign div_ge = div_sh >= {1'b0, den_q};

	logic signed [17:0] pos;
	logic [7:0] pos_clamped;
	always_comb begin
		pos = $signed({1'b0, num_q});
		if (neg_q)
			pos = -pos;
		if (pos < $signed({10'd0, smin_q}))
			pos_clamped = smin_q;
		else if (pos > $signed({10'd0, smax_q}))
			pos_clamped = smax_q;
		else
			pos_clamped = pos[7:0];
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_SQ_A;
			ST_SQ_A:     state_d = ST_SQ_B;
			ST_SQ_B:     state_d = ST_SQ_C;
			ST_SQ_C:     state_d = ST_SQRT;
			ST_SQRT:     if (cnt_q == CW'(15)) state_d = ST_COR_INIT;
			ST_COR_INIT: state_d = ST_COR_RUN;
			ST_COR_RUN:  if (cnt_q == CW'(CORDIC_STEPS - 1)) state_d = ST_COR_DONE;
			ST_COR_DONE: state_d = axis_q ? ST_F_RATE : ST_COR_INIT;
			ST_F_RATE:   state_d = ST_F_GAIN;
			ST_F_GAIN:   state_d = ST_F_PRED;
			ST_F_PRED:   state_d = ST_F_LO;
			ST_F_LO:     state_d = ST_F_HI;
			ST_F_HI:     state_d = ST_F_SUM;
			ST_F_SUM:    state_d = axis_q ? ST_SV_INIT : ST_F_RATE;
			ST_SV_INIT:  state_d = ST_SV_DIV;
			ST_SV_DIV:   if (cnt_q == CW'(16)) state_d = ST_SV_DONE;
			ST_SV_DONE:  state_d = axis_q ? ST_DONE : ST_SV_INIT;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: counter, axis select, angles, registers, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			angle_x_q   <= '0;
			angle_y_q   <= '0;
			alpha_q     <= 16'd62915;
			gain_q      <= 24'd16393;
			range_q     <= 8'd60;
			smin_q      <= 8'd10;
			smax_q      <= 8'd170;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ALPHA:     alpha_q <= cfg_data[15:0];
					REG_GAIN:      gain_q  <= cfg_data;
					REG_RANGE:     range_q <= cfg_data[7:0];
					REG_SERVO_MIN: smin_q  <= cfg_data[7:0];
					REG_SERVO_MAX: smax_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_SQ_C, ST_COR_INIT, ST_SV_INIT: cnt_q <= '0;
				ST_SQRT, ST_COR_RUN, ST_SV_DIV:   cnt_q <= cnt_q + CW'(1);
				ST_COR_DONE, ST_F_SUM, ST_SV_DONE: axis_q <= !axis_q;
				default: ;
			endcase
			if (state_q == ST_F_SUM) begin
				if (axis_q)
					angle_y_q <= new_ang;
				else
					angle_x_q <= new_ang;
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == ST_IDLE && in_valid) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			gx_q <= gyro_x;
			gy_q <= gyro_y;
			ms_q <= elapsed_ms;
		end
		case (state_q)
			ST_SQ_B: n_q <= prod_q[31:0];
			ST_SQ_C: begin
				n_q    <= n_q + prod_q[31:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				n_q <= n_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[14:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[14:0], 1'b0};
				end
			end
			ST_COR_INIT: begin
				zero_q <= (cx_src == 18'sd0) && (cy_src == 18'sd0);
				cx_q   <= 40'(cx_abs) <<< 20;
				cy_q   <= 40'(cy_abs) <<< 20;
				if (!cx_neg)
					cz_q <= '0;
				else if (cy_src >= 0)
					cz_q <= HALF_TURN;
				else
					cz_q <= -HALF_TURN;
			end
			ST_COR_RUN: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					cz_q <= cz_q + t_ang;
				end else begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					cz_q <= cz_q - t_ang;
				end
			end
			ST_COR_DONE: begin
				if (axis_q)
					acc_y_q <= z_ang;
				else
					acc_x_q <= z_ang;
			end
			ST_F_PRED: d_q <= p_c - (42'(acc_sel) <<< 8);
			ST_F_HI:   lo_q <= prod_q[37:0];
			ST_SV_INIT: begin
				neg_q  <= num < 0;
				num_q  <= num_abs[16:0];
				den_q  <= {r_eff, 1'b0};
				srem_q <= '0;
			end
			ST_SV_DIV: begin
				srem_q <= div_ge ? (div_sh - {1'b0, den_q}) : div_sh;
				num_q  <= {num_q[15:0], div_ge};
			end
			ST_SV_DONE: begin
				if (axis_q)
					servo_y_q <= pos_clamped;
				else
					servo_x_q <= pos_clamped;
			end
			ST_DONE: begin
				if (out_free) begin
					tilt_x_q <= angle_x_q;
					tilt_y_q <= angle_y_q;
					sout_x_q <= servo_x_q;
					sout_y_q <= servo_y_q;
				end
			end
			default: ;
		endcase
	end

	// The kept angles never leave the half-turn range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_x_q <= ANGLE_LIMIT && angle_x_q >= -ANGLE_LIMIT
		&& angle_y_q <= ANGLE_LIMIT && angle_y_q >= -ANGLE_LIMIT)
		else $error("tilt angle out of range");

	// An accepted item starts the sequence at the squaring step.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_SQ_A)
		else $error("accepted item did not start the sequence");

	// The CORDIC counter stays inside the step count.
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COR_RUN |-> cnt_q < CW'(CORDIC_STEPS))
		else $error("CORDIC step counter overrun");

	// A result is loaded only into a free output register.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && out_stall |=> state_q == ST_DONE)
		else $error("result overwritten while waiting");

endmodule

[tb/tilt_complementary_filter_servo_tb.sv]
// ----------------------------------------------------------------------------
// tilt_complementary_filter_servo_tb
// Self-checking bench for the two-axis complementary tilt filter. A queue of
// IMU samples feeds a clocked driver, and a clocked monitor checks every
// result against a bit-true predictor of the CORDIC angles, the filter and
// the servo mapping. The run steps through several register settings, with
// random gaps on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_servo_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcfs_pkg::*;

	localparam int STEPS = 16;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 150;
	localparam logic [2:0] REG_SPARE_A = 3'd5;
	localparam logic [2:0] REG_SPARE_B = 3'd6;
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam longint ANGLE_MAX = 23040;
	localparam longint PRED_MAX = longint'(1) <<< 40;

	localparam longint ATAN_DEG16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [15:0] ax, ay, az, gx, gy;
		logic [15:0] ms;
	} imu_sample_t;

	typedef struct {
		logic signed [15:0] tx, ty;
		logic [7:0] sx, sy;
	} tilt_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [15:0] gyro_x = '0, gyro_y = '0;
	logic [15:0] elapsed_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] tilt_x, tilt_y;
	logic [7:0] servo_x, servo_y;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	tilt_complementary_filter_servo #(.CORDIC_STEPS(STEPS)) uut (.*);

	always #1 clk = ~clk;

	// Predictor state and register copy.
	logic signed [15:0] angle_x_q, angle_y_q;
	logic [15:0] alpha_q;
	logic [23:0] gain_q;
	logic [7:0] range_q, smin_q, smax_q;

	imu_sample_t samples_pending[$];
	tilt_result_t tilt_expect[$];
	int errors = 0;
	int n_items = 0, n_results = 0;
	int idle_pct = 15;
	int hold_req = 0;
	logic sender_hold = 1'b0;

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
			n_results);
	endtask

	function automatic longint tilt_atan2(input longint y0, input longint x0);
		longint x, y, z, dx, dy, r;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		x = x * (longint'(1) <<< 20);
		y = y * (longint'(1) <<< 20);
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += ATAN_DEG16[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_DEG16[i];
			end
		end
		r = (z + 256) >>> 9;
		return (r > ANGLE_MAX) ? ANGLE_MAX : (r < -ANGLE_MAX) ? -ANGLE_MAX : r;
	endfunction

	function automatic longint floor_sqrt(input longint n);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= n)
			r = (r + 1 > 1024 && (r + 1024) * (r + 1024) <= n) ? r + 1024 : r + 1;
		return r;
	endfunction

	function automatic longint blend_axis(input longint angle, input longint rate,
			input longint ms, input longint acc);
		longint g, p, s;
		g = (rate * ms * longint'(gain_q) + 32768) >>> 16;
		p = angle * 256 + g;
		p = (p > PRED_MAX) ? PRED_MAX : (p < -PRED_MAX) ? -PRED_MAX : p;
		s = longint'(alpha_q) * p + (65536 - longint'(alpha_q)) * acc * 256;
		s = (s + (longint'(1) <<< 23)) >>> 24;
		return (s > ANGLE_MAX) ? ANGLE_MAX : (s < -ANGLE_MAX) ? -ANGLE_MAX : s;
	endfunction

	function automatic logic [7:0] servo_degrees(input longint angle);
		longint r, deg, pos;
		r = (range_q == 0) ? 1 : longint'(range_q);
		deg = angle / 128;
		pos = (deg + r) * 180 / (2 * r);
		// The lower clamp is tested first, so it wins when min exceeds max.
		if (pos < longint'(smin_q))
			pos = smin_q;
		else if (pos > longint'(smax_q))
			pos = smax_q;
		return pos[7:0];
	endfunction

	function automatic tilt_result_t predict_tilt(input imu_sample_t s);
		tilt_result_t t;
		longint ax, ay, az, mag, acc_x, acc_y;
		ax = s.ax;
		ay = s.ay;
		az = s.az;
		mag = floor_sqrt(ay * ay + az * az);
		acc_x = tilt_atan2(ay, az);
		acc_y = tilt_atan2(-ax, mag);
		angle_x_q = 16'(blend_axis(angle_x_q, s.gx, s.ms, acc_x));
		angle_y_q = 16'(blend_axis(angle_y_q, s.gy, s.ms, acc_y));
		t.tx = angle_x_q;
		t.ty = angle_y_q;
		t.sx = servo_degrees(angle_x_q);
		t.sy = servo_degrees(angle_y_q);
		return t;
	endfunction

	// Acceptance of input items: predict and retire the offered sample.
	logic in_taken = 1'b0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			imu_sample_t s;
			s = samples_pending.pop_front();
			tilt_expect.push_back(predict_tilt(s));
			n_items++;
			in_taken <= 1'b1;
		end else begin
			in_taken <= 1'b0;
		end
	end

	// Driver: holds an offered item until taken, with random gap bursts.
	int gap_left = 0;
	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (samples_pending.size() == 0 || sender_hold) begin
				in_valid <= 1'b0;
			end else if ($urandom_range(99) < idle_pct) begin
				gap_left <= $urandom_range(8, 0);
				in_valid <= 1'b0;
			end else begin
				accel_x <= samples_pending[0].ax;
				accel_y <= samples_pending[0].ay;
				accel_z <= samples_pending[0].az;
				gyro_x <= samples_pending[0].gx;
				gyro_y <= samples_pending[0].gy;
				elapsed_ms <= samples_pending[0].ms;
				in_valid <= 1'b1;
			end
		end
	end

	// Receiver stall: random bursts, plus a long hold-off on request.
	int stall_left = 0, hold_seen = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			stall_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < idle_pct) begin
			stall_left <= $urandom_range(8, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			tilt_result_t w;
			if (tilt_expect.size() == 0) begin
				errors++;
				$display("unexpected result: tilt %0d %0d", tilt_x, tilt_y);
			end else begin
				w = tilt_expect.pop_front();
				if (tilt_x !== w.tx) report("tilt_x", tilt_x, w.tx);
				if (tilt_y !== w.ty) report("tilt_y", tilt_y, w.ty);
				if (servo_x !== w.sx) report("servo_x", servo_x, w.sx);
				if (servo_y !== w.sy) report("servo_y", servo_y, w.sy);
			end
			n_results++;
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", tilt_expect.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ALPHA:     alpha_q = value[15:0];
			REG_GAIN:      gain_q = value;
			REG_RANGE:     range_q = value[7:0];
			REG_SERVO_MIN: smin_q = value[7:0];
			REG_SERVO_MAX: smax_q = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (samples_pending.size() != 0 || tilt_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push(input int ax, ay, az, gx, gy, ms);
		imu_sample_t s;
		s.ax = 16'(ax);
		s.ay = 16'(ay);
		s.az = 16'(az);
		s.gx = 16'(gx);
		s.gy = 16'(gy);
		s.ms = 16'(ms);
		samples_pending.push_back(s);
	endtask

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 2)
				push($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				// Plausible motion: accelerations within +-16000, modest rates, short steps.
				push($urandom_range(32000) - 16000, $urandom_range(32000) - 16000,
					$urandom_range(32000) - 16000, $urandom_range(6000) - 3000,
					$urandom_range(6000) - 3000, $urandom_range(40, 1));
		end
	endtask

	initial begin
		alpha_q = 16'd62915;
		gain_q = 24'd16393;
		range_q = 8'd60;
		smin_q = 8'd10;
		smax_q = 8'd170;
		angle_x_q = '0;
		angle_y_q = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed samples at the default settings.
		push(0, 0, 0, 0, 0, 0);
		push(0, 0, 0, 0, 0, 65535);
		push(0, 0, -16384, 0, 0, 10);
		push(0, -1, -16384, 0, 0, 10);
		push(0, 100, -16384, 0, 0, 10);
		push(-32768, -32768, -32768, -32768, -32768, 65535);
		push(32767, 32767, 32767, 32767, 32767, 65535);
		push(-32768, 0, 0, 32767, -32768, 65535);
		push(32767, 0, 0, -32768, 32767, 65535);
		push(0, 32767, 0, 0, 0, 1);
		push(0, -32768, 0, 0, 0, 1);
		push(0, 0, 16384, 0, 0, 20);
		push(16384, 0, 16384, 500, -500, 20);
		push(-16384, 0, 16384, -500, 500, 20);
		push(0, 16384, 16384, 0, 0, 0);
		push(0, -16384, -16384, 1, -1, 65535);
		push(1, 1, 1, 1, 1, 1);
		push(-1, -1, -1, -1, -1, 1);
		drain();

		for (int ph = 1; ph <= 8; ph++) begin
			case (ph)
				1: begin
					write_reg(REG_ALPHA, 24'd0);
					write_reg(REG_RANGE, 24'd0);
					write_reg(REG_SPARE, 24'hFFFFFF);
				end
				2: begin
					write_reg(REG_ALPHA, 24'd65535);
					write_reg(REG_GAIN, 24'hFFFFFF);
					write_reg(REG_RANGE, 24'd180);
					write_reg(REG_SERVO_MIN, 24'd0);
					write_reg(REG_SERVO_MAX, 24'd180);
				end
				3: begin
					write_reg(REG_GAIN, 24'd0);
					write_reg(REG_RANGE, 24'd255);
					write_reg(REG_SERVO_MIN, 24'd150);
					write_reg(REG_SERVO_MAX, 24'd30);
					write_reg(REG_SPARE_A, 24'd77);
				end
				4: begin
					write_reg(REG_ALPHA, 24'd62915);
					write_reg(REG_GAIN, 24'd16393);
					write_reg(REG_RANGE, 24'd1);
					write_reg(REG_SERVO_MIN, 24'd180);
					write_reg(REG_SERVO_MAX, 24'd0);
					write_reg(REG_SPARE_B, 24'd1);
				end
				default: begin
					write_reg(REG_ALPHA, 24'($urandom));
					write_reg(REG_GAIN, 24'($urandom_range(200000)));
					write_reg(REG_RANGE, 24'($urandom_range(180, 1)));
					write_reg(REG_SERVO_MIN, 24'($urandom_range(60)));
					write_reg(REG_SERVO_MAX, 24'($urandom_range(180, 120)));
				end
			endcase
			idle_pct = (ph == 8) ? 0 : (ph == 5) ? 40 : 15;
			push_random(204);
			if (ph == 2)
				hold_req++;
			if (ph == 6) begin
				// Stop offering halfway until every pending result is back.
				while (samples_pending.size() > 100)
					@(posedge clk);
				sender_hold = 1'b1;
				while (tilt_expect.size() != 0)
					@(posedge clk);
				sender_hold = 1'b0;
			end
			drain();
		end

		if (tilt_expect.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", tilt_expect.size());
		end
		$display("covered %0d samples and %0d results over 9 register settings,",
			n_items, n_results);
		$display("including range and clamp extremes and a %0d-cycle output hold",
			LONG_HOLD);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[tilt_complementary_filter_servo.f]
rtl/core/tcfs_pkg.sv
rtl/core/tilt_complementary_filter_servo.sv
tb/tilt_complementary_filter_servo_tb.sv
